// ===== rtl/sfdd_pkg.sv =====
// Shared constants, types and helpers of the sensor frame deframer and decoder.
`default_nettype none
package sfdd_pkg;

	localparam int BUFFER_DEPTH = 512;
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int LW = 9;
	localparam int PADDR_W = 4;

	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] TAIL_BYTE = 8'h55;
	localparam logic [LW-1:0] FRAME_OVERHEAD = 9'd7;
	localparam logic [7:0] CMD_ENV = 8'h01;
	localparam logic [7:0] CMD_LIGHT = 8'h02;
	localparam logic [LW-1:0] ENV_MIN_LEN = 9'd11;
	localparam logic [LW-1:0] LIGHT_LEN = 9'd9;
	localparam logic [CW-1:0] LEN_OFFSET = CW'(4);
	localparam logic [CW-1:0] MIN_HELD = CW'(5);
	localparam logic [3:0] FIELD_FIRST_OFF = 4'd3;
	localparam logic [3:0] FIELD_LAST_OFF = 4'd10;

	localparam logic [15:0] GAS_LOW_RESET = 16'd500;
	localparam logic [15:0] GAS_HIGH_RESET = 16'd1500;

	localparam logic [1:0] REG_GAS_LOW = 2'd0;
	localparam logic [1:0] REG_GAS_HIGH = 2'd1;
	localparam logic [1:0] REG_LINK_OPEN = 2'd2;

	localparam logic [2:0] KIND_ENV = 3'd0;
	localparam logic [2:0] KIND_LIGHT = 3'd1;
	localparam logic [2:0] KIND_UNKNOWN = 3'd2;
	localparam logic [2:0] KIND_ENV_LEN_ERR = 3'd3;
	localparam logic [2:0] KIND_LIGHT_LEN_ERR = 3'd4;

	localparam logic [1:0] LEVEL_LOW = 2'd0;
	localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
	localparam logic [1:0] LEVEL_HIGH = 2'd2;

	localparam logic [1:0] ALARM_NONE = 2'd0;
	localparam logic [1:0] ALARM_RAISE = 2'd1;
	localparam logic [1:0] ALARM_CLEAR = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  command;
		logic [7:0]  temperature;
		logic [7:0]  humidity;
		logic [7:0]  gas_digital;
		logic [15:0] gas_analog;
		logic [7:0]  sensor_status;
		logic [1:0]  gas_level;
		logic [15:0] lux;
		logic [1:0]  alarm_send;
		logic        last;
	} res_t;

	typedef logic [7:0][7:0] field_bytes_t;

	function automatic logic [AW-1:0] buf_addr(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(BUFFER_DEPTH)) begin
			sum = sum - SW'(BUFFER_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sfdd_buffer.sv =====
// Circular byte buffer memory with one write port and one registered read port.
`default_nettype none
module sfdd_buffer (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [sfdd_pkg::AW-1:0] wr_addr,
	input  wire logic [7:0]            wr_data,
	input  wire logic                  rd_en,
	input  wire logic [sfdd_pkg::AW-1:0] rd_addr,
	output logic      [7:0]            rd_data
);
	import sfdd_pkg::*;

	logic [7:0] mem_q [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sfdd_decode.sv =====
// Frame decoder that turns the fetched frame bytes into one result and the next alarm state.
`default_nettype none
module sfdd_decode (
	input  wire logic                     [7:0][7:0] fbytes,
	input  wire logic [sfdd_pkg::LW-1:0]  len,
	input  wire logic                     alarm_active,
	input  wire logic                     link_open,
	input  wire logic [15:0]              gas_low_limit,
	input  wire logic [15:0]              gas_high_limit,
	output sfdd_pkg::res_t                res,
	output logic                          alarm_next
);
	import sfdd_pkg::*;

	logic [7:0]  cmd;
	logic [15:0] ana;
	logic [7:0]  status;
	logic [1:0]  level;

	assign cmd = fbytes[0];
	assign ana = {fbytes[5], fbytes[6]};
	assign status = fbytes[7];

	always_comb begin
		if (ana < gas_low_limit) begin
			level = LEVEL_LOW;
		end else if (ana < gas_high_limit) begin
			level = LEVEL_MEDIUM;
		end else begin
			level = LEVEL_HIGH;
		end
	end

	always_comb begin
		res = '0;
		res.command = cmd;
		alarm_next = alarm_active;
		if (cmd == CMD_ENV) begin
			if (len < ENV_MIN_LEN) begin
				res.kind = KIND_ENV_LEN_ERR;
			end else begin
				res.kind = KIND_ENV;
				res.temperature = fbytes[2];
				res.humidity = fbytes[3];
				res.gas_digital = fbytes[4];
				res.gas_analog = ana;
				res.sensor_status = status;
				res.gas_level = level;
				if (status == 8'd0 && alarm_active) begin
					alarm_next = 1'b0;
					res.alarm_send = link_open ? ALARM_CLEAR : ALARM_NONE;
				end else if (status != 8'd0 && !alarm_active) begin
					alarm_next = 1'b1;
					res.alarm_send = link_open ? ALARM_RAISE : ALARM_NONE;
				end
			end
		end else if (cmd == CMD_LIGHT) begin
			if (len != LIGHT_LEN) begin
				res.kind = KIND_LIGHT_LEN_ERR;
			end else begin
				res.kind = KIND_LIGHT;
				res.lux = {fbytes[2], fbytes[3]};
			end
		end else begin
			res.kind = KIND_UNKNOWN;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sensor_frame_deframer_decoder.sv =====
// Top level of the sensor frame deframer and decoder.
// A byte that completes no frame is checked before the input takes the next one;
// finding the header costs one memory read for each byte looked at.
// A completed frame goes through a tail read, eight field reads and a decode.
// A bad tail drops one byte and rescans through the buffer read port.
// Reset clears the control state, empties the buffer and loads the default limits;
// the buffer memory itself is not cleared, so no clearing pass is needed.
`default_nettype none
module sensor_frame_deframer_decoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sfdd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [2:0]                   kind,
	output logic      [7:0]                   command,
	output logic      [7:0]                   temperature,
	output logic      [7:0]                   humidity,
	output logic      [7:0]                   gas_digital,
	output logic      [15:0]                  gas_analog,
	output logic      [7:0]                   sensor_status,
	output logic      [1:0]                   gas_level,
	output logic      [15:0]                  lux,
	output logic      [1:0]                   alarm_send,
	output logic                              last
);
	import sfdd_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE       = 9'b000000001,
		ST_CHECK      = 9'b000000010,
		ST_HEAD_WAIT  = 9'b000000100,
		ST_LEN_WAIT   = 9'b000001000,
		ST_TAIL_WAIT  = 9'b000010000,
		ST_FETCH      = 9'b000100000,
		ST_FETCH_LAST = 9'b001000000,
		ST_DECODE     = 9'b010000000,
		ST_FINISH     = 9'b100000000
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic           head_ok_q;
	logic           len_ok_q;
	logic [LW-1:0]  len_q;
	logic [3:0]     off_q;
	logic           fetch_s1;
	logic [2:0]     fetch_off_s1;
	field_bytes_t   fbytes_q;
	logic           alarm_q;
	res_t           pend_q;
	logic           pend_valid_q;
	res_t           out_q;
	logic           out_valid_q;
	logic [15:0]    gas_low_q;
	logic [15:0]    gas_high_q;
	logic           link_open_q;

	logic           in_accept;
	logic           out_free;
	logic           out_load;
	logic           cfg_write;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;
	res_t           dec_res;
	logic           alarm_next;
	logic           decode_go;
	state_t         stop_state;

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign decode_go = !pend_valid_q || out_free;
	assign stop_state = pend_valid_q ? ST_FINISH : ST_IDLE;
	assign out_load = (state_q == ST_DECODE && decode_go && pend_valid_q)
		|| (state_q == ST_FINISH && out_free);

	assign wr_en = in_accept && (count_q < CW'(BUFFER_DEPTH));
	assign wr_addr = buf_addr(head_q, count_q);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q;
		if (state_q == ST_CHECK && count_q != '0) begin
			if (!head_ok_q) begin
				rd_en = 1'b1;
			end else if (count_q >= MIN_HELD) begin
				rd_en = 1'b1;
				if (!len_ok_q) begin
					rd_addr = buf_addr(head_q, LEN_OFFSET);
				end else begin
					rd_addr = buf_addr(head_q, CW'(len_q) - CW'(1));
				end
			end
		end else if (state_q == ST_FETCH) begin
			rd_en = 1'b1;
			rd_addr = buf_addr(head_q, CW'(off_q));
		end
	end

	sfdd_buffer u_buffer (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sfdd_decode u_decode (
		.fbytes         (fbytes_q),
		.len            (len_q),
		.alarm_active   (alarm_q),
		.link_open      (link_open_q),
		.gas_low_limit  (gas_low_q),
		.gas_high_limit (gas_high_q),
		.res            (dec_res),
		.alarm_next     (alarm_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_low_q <= GAS_LOW_RESET;
			gas_high_q <= GAS_HIGH_RESET;
			link_open_q <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_GAS_LOW: gas_low_q <= pwdata[15:0];
				REG_GAS_HIGH: gas_high_q <= pwdata[15:0];
				REG_LINK_OPEN: link_open_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAS_LOW: prdata = {16'd0, gas_low_q};
			REG_GAS_HIGH: prdata = {16'd0, gas_high_q};
			REG_LINK_OPEN: prdata = {31'd0, link_open_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			head_ok_q <= 1'b0;
			len_ok_q <= 1'b0;
			off_q <= FIELD_FIRST_OFF;
			fetch_s1 <= 1'b0;
			alarm_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fetch_s1 <= (state_q == ST_FETCH);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (count_q == '0) begin
						head_ok_q <= 1'b0;
						len_ok_q <= 1'b0;
						state_q <= stop_state;
					end else if (!head_ok_q) begin
						state_q <= ST_HEAD_WAIT;
					end else if (count_q < MIN_HELD) begin
						state_q <= stop_state;
					end else if (!len_ok_q) begin
						state_q <= ST_LEN_WAIT;
					end else if (count_q < CW'(len_q)) begin
						state_q <= stop_state;
					end else begin
						state_q <= ST_TAIL_WAIT;
					end
				end
				ST_HEAD_WAIT: begin
					if (rd_data == HDR_BYTE) begin
						head_ok_q <= 1'b1;
					end else begin
						head_q <= buf_addr(head_q, CW'(1));
						count_q <= count_q - CW'(1);
					end
					state_q <= ST_CHECK;
				end
				ST_LEN_WAIT: begin
					len_ok_q <= 1'b1;
					state_q <= ST_CHECK;
				end
				ST_TAIL_WAIT: begin
					if (rd_data != TAIL_BYTE) begin
						head_q <= buf_addr(head_q, CW'(1));
						count_q <= count_q - CW'(1);
						head_ok_q <= 1'b0;
						len_ok_q <= 1'b0;
						state_q <= ST_CHECK;
					end else begin
						off_q <= FIELD_FIRST_OFF;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					off_q <= off_q + 4'd1;
					if (off_q == FIELD_LAST_OFF) begin
						state_q <= ST_FETCH_LAST;
					end
				end
				ST_FETCH_LAST: begin
					state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (decode_go) begin
						pend_valid_q <= 1'b1;
						alarm_q <= alarm_next;
						head_q <= buf_addr(head_q, CW'(len_q));
						count_q <= count_q - CW'(len_q);
						head_ok_q <= 1'b0;
						len_ok_q <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LEN_WAIT) begin
			len_q <= LW'(rd_data) + FRAME_OVERHEAD;
		end
		if (state_q == ST_FETCH) begin
			fetch_off_s1 <= 3'(off_q - FIELD_FIRST_OFF);
		end
		if (fetch_s1) begin
			fbytes_q[fetch_off_s1] <= rd_data;
		end
		if (state_q == ST_DECODE && decode_go) begin
			pend_q <= dec_res;
			if (pend_valid_q) begin
				out_q <= {pend_q[$bits(res_t)-1:1], 1'b0};
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q <= {pend_q[$bits(res_t)-1:1], 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign command = out_q.command;
	assign temperature = out_q.temperature;
	assign humidity = out_q.humidity;
	assign gas_digital = out_q.gas_digital;
	assign gas_analog = out_q.gas_analog;
	assign sensor_status = out_q.sensor_status;
	assign gas_level = out_q.gas_level;
	assign lux = out_q.lux;
	assign alarm_send = out_q.alarm_send;
	assign last = out_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUFFER_DEPTH))
		else $error("buffer count exceeds the buffer depth");

	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (count_q < CW'(BUFFER_DEPTH)) |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted byte not added to the buffer count");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("a decoded result is left pending while idle");

	a_len_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		len_ok_q |-> head_ok_q && count_q >= MIN_HELD)
		else $error("frame length held without a confirmed header");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_free |=> out_valid_q && out_q.last)
		else $error("closing transaction of a byte is not marked last");

endmodule
`default_nettype wire

// ===== tb/sfdd_frame_checker.sv =====
// Checker that predicts and compares the decoded frames of the sensor frame deframer.
`default_nettype none
module sfdd_frame_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sfdd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	input  wire logic                         pready,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [7:0]                   rx_byte,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [2:0]                   kind,
	input  wire logic [7:0]                   command,
	input  wire logic [7:0]                   temperature,
	input  wire logic [7:0]                   humidity,
	input  wire logic [7:0]                   gas_digital,
	input  wire logic [15:0]                  gas_analog,
	input  wire logic [7:0]                   sensor_status,
	input  wire logic [1:0]                   gas_level,
	input  wire logic [15:0]                  lux,
	input  wire logic [1:0]                   alarm_send,
	input  wire logic                         last,
	output int                                fail_count,
	output int                                pending_count,
	output int                                predicted_count
);
	import sfdd_pkg::*;

	localparam int MAX_RESULTS_PER_BYTE = 37;

	logic [7:0]  held_bytes[$];
	res_t        decoded_due[$];
	logic        alarm_latched;
	logic [15:0] low_limit;
	logic [15:0] high_limit;
	logic        link_up;
	int          mismatches;
	int          predicted;

	function automatic res_t decode_held(input int flen);
		res_t r;
		r = '0;
		r.command = held_bytes[3];
		if (held_bytes[3] == CMD_ENV) begin
			if (flen < int'(ENV_MIN_LEN)) begin
				r.kind = KIND_ENV_LEN_ERR;
			end else begin
				r.kind = KIND_ENV;
				r.temperature = held_bytes[5];
				r.humidity = held_bytes[6];
				r.gas_digital = held_bytes[7];
				r.gas_analog = {held_bytes[8], held_bytes[9]};
				r.sensor_status = held_bytes[10];
				if (r.gas_analog < low_limit) begin
					r.gas_level = LEVEL_LOW;
				end else if (r.gas_analog < high_limit) begin
					r.gas_level = LEVEL_MEDIUM;
				end else begin
					r.gas_level = LEVEL_HIGH;
				end
				if (r.sensor_status == 8'h00 && alarm_latched) begin
					alarm_latched = 1'b0;
					if (link_up) begin
						r.alarm_send = ALARM_CLEAR;
					end
				end else if (r.sensor_status != 8'h00 && !alarm_latched) begin
					alarm_latched = 1'b1;
					if (link_up) begin
						r.alarm_send = ALARM_RAISE;
					end
				end
			end
		end else if (held_bytes[3] == CMD_LIGHT) begin
			if (flen != int'(LIGHT_LEN)) begin
				r.kind = KIND_LIGHT_LEN_ERR;
			end else begin
				r.kind = KIND_LIGHT;
				r.lux = {held_bytes[5], held_bytes[6]};
			end
		end else begin
			r.kind = KIND_UNKNOWN;
		end
		return r;
	endfunction

	task automatic absorb_rx_byte(input logic [7:0] b);
		res_t r;
		res_t prev;
		int   made;
		int   flen;
		made = 0;
		prev = '0;
		if (held_bytes.size() < BUFFER_DEPTH) begin
			held_bytes.push_back(b);
		end
		while (made < MAX_RESULTS_PER_BYTE) begin
			while (held_bytes.size() != 0 && held_bytes[0] != HDR_BYTE) begin
				void'(held_bytes.pop_front());
			end
			if (held_bytes.size() < int'(MIN_HELD)) begin
				break;
			end
			flen = int'(FRAME_OVERHEAD) + int'(held_bytes[4]);
			if (held_bytes.size() < flen) begin
				break;
			end
			if (held_bytes[flen-1] != TAIL_BYTE) begin
				void'(held_bytes.pop_front());
				continue;
			end
			r = decode_held(flen);
			if (made != 0) begin
				decoded_due.push_back(prev);
			end
			prev = r;
			made++;
			repeat (flen) void'(held_bytes.pop_front());
		end
		if (made != 0) begin
			prev.last = 1'b1;
			decoded_due.push_back(prev);
		end
		predicted += made;
	endtask

	task automatic compare_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (decoded_due.size() == 0) begin
			$display("%0t: unexpected transaction, expected none, actual kind %0h command %0h",
				$time, kind, command);
			mismatches++;
		end else begin
			want = decoded_due.pop_front();
			compare_field("kind", 16'(want.kind), 16'(kind));
			compare_field("command", 16'(want.command), 16'(command));
			compare_field("temperature", 16'(want.temperature), 16'(temperature));
			compare_field("humidity", 16'(want.humidity), 16'(humidity));
			compare_field("gas_digital", 16'(want.gas_digital), 16'(gas_digital));
			compare_field("gas_analog", want.gas_analog, gas_analog);
			compare_field("sensor_status", 16'(want.sensor_status), 16'(sensor_status));
			compare_field("gas_level", 16'(want.gas_level), 16'(gas_level));
			compare_field("lux", want.lux, lux);
			compare_field("alarm_send", 16'(want.alarm_send), 16'(alarm_send));
			compare_field("last", 16'(want.last), 16'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes.delete();
			decoded_due.delete();
			alarm_latched = 1'b0;
			low_limit = GAS_LOW_RESET;
			high_limit = GAS_HIGH_RESET;
			link_up = 1'b0;
			mismatches = 0;
			predicted = 0;
			fail_count <= 0;
			pending_count <= 0;
			predicted_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_GAS_LOW: low_limit = pwdata[15:0];
					REG_GAS_HIGH: high_limit = pwdata[15:0];
					REG_LINK_OPEN: link_up = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				absorb_rx_byte(rx_byte);
			end
			fail_count <= mismatches;
			pending_count <= decoded_due.size();
			predicted_count <= predicted;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_sensor_frame_deframer_decoder.sv =====
// Top of the testbench: clock, reset, register writes, frame stimulus and the verdict.
`default_nettype none
module tb_sensor_frame_deframer_decoder;
	import sfdd_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES = 400;
	localparam logic [7:0] ENV_BODY_MIN = 8'(ENV_MIN_LEN - FRAME_OVERHEAD);
	localparam logic [7:0] ENV_BODY = ENV_BODY_MIN + 8'd1;
	localparam logic [7:0] LIGHT_BODY = 8'(LIGHT_LEN - FRAME_OVERHEAD);

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         kind;
	logic [7:0]         command;
	logic [7:0]         temperature;
	logic [7:0]         humidity;
	logic [7:0]         gas_digital;
	logic [15:0]        gas_analog;
	logic [7:0]         sensor_status;
	logic [1:0]         gas_level;
	logic [15:0]        lux;
	logic [1:0]         alarm_send;
	logic               last;
	int                 fail_count;
	int                 pending_count;
	int                 predicted_count;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          bytes_sent = 0;
	logic [15:0] cfg_low = GAS_LOW_RESET;
	logic [15:0] cfg_high = GAS_HIGH_RESET;
	logic [7:0]  tx_bytes[$];
	logic [7:0]  field_bytes[$];

	sensor_frame_deframer_decoder dut (.*);

	sfdd_frame_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic transmit();
		while (tx_bytes.size() != 0) begin
			send_byte(tx_bytes.pop_front());
		end
	endtask

	task automatic add_frame(input logic [7:0] cmd, input logic [7:0] len,
		input logic [7:0] tail);
		tx_bytes.push_back(HDR_BYTE);
		tx_bytes.push_back(8'($urandom));
		tx_bytes.push_back(8'($urandom));
		tx_bytes.push_back(cmd);
		tx_bytes.push_back(len);
		for (int k = 0; k <= int'(len); k++) begin
			if (field_bytes.size() != 0) begin
				tx_bytes.push_back(field_bytes.pop_front());
			end else begin
				tx_bytes.push_back(8'($urandom));
			end
		end
		tx_bytes.push_back(tail);
		field_bytes.delete();
	endtask

	task automatic add_env(input logic [7:0] status, input logic [15:0] ana,
		input logic [7:0] len);
		field_bytes.push_back(8'($urandom));
		field_bytes.push_back(8'($urandom));
		field_bytes.push_back(8'($urandom));
		field_bytes.push_back(ana[15:8]);
		field_bytes.push_back(ana[7:0]);
		field_bytes.push_back(status);
		add_frame(CMD_ENV, len, TAIL_BYTE);
	endtask

	task automatic add_light(input logic [15:0] value, input logic [7:0] len);
		field_bytes.push_back(value[15:8]);
		field_bytes.push_back(value[7:0]);
		add_frame(CMD_LIGHT, len, TAIL_BYTE);
	endtask

	function automatic logic [7:0] wrong_tail();
		logic [7:0] t;
		t = 8'($urandom);
		return (t == TAIL_BYTE) ? ~t : t;
	endfunction

	function automatic logic [15:0] pick_ana();
		case ($urandom_range(2))
			0: return 16'($urandom);
			1: return cfg_low + 16'($urandom_range(2)) - 16'd1;
			default: return cfg_high + 16'($urandom_range(2)) - 16'd1;
		endcase
	endfunction

	function automatic logic [7:0] pick_status();
		return ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	task automatic add_wrapped_frames(input int inner);
		int outer_len;
		repeat (inner) begin
			if ($urandom_range(1) == 0) begin
				add_light(16'($urandom), LIGHT_BODY);
			end else begin
				add_env(pick_status(), pick_ana(), ENV_BODY);
			end
		end
		field_bytes = tx_bytes;
		tx_bytes.delete();
		outer_len = field_bytes.size() - 1 + $urandom_range(3);
		if (outer_len > 255) begin
			outer_len = 255;
		end
		add_frame(8'($urandom), 8'(outer_len), wrong_tail());
	endtask

	task automatic random_frame();
		int         pick;
		logic [7:0] len;
		logic [7:0] cmd;
		pick = $urandom_range(99);
		if (pick < 40) begin
			if ($urandom_range(39) == 0) begin
				len = 8'($urandom_range(255, 9));
			end else begin
				len = 8'($urandom_range(8, 4));
			end
			add_env(pick_status(), pick_ana(), len);
		end else if (pick < 58) begin
			add_light(16'($urandom), LIGHT_BODY);
		end else if (pick < 65) begin
			len = 8'($urandom_range(10));
			if (len == LIGHT_BODY) begin
				len = len + 8'd1;
			end
			add_light(16'($urandom), len);
		end else if (pick < 72) begin
			add_env(pick_status(), pick_ana(), 8'($urandom_range(3)));
		end else if (pick < 80) begin
			cmd = 8'($urandom);
			if (cmd == CMD_ENV || cmd == CMD_LIGHT) begin
				cmd = cmd ^ 8'h80;
			end
			add_frame(cmd, 8'($urandom_range(6)), TAIL_BYTE);
		end else if (pick < 90) begin
			add_wrapped_frames($urandom_range(3, 1));
		end else if (pick < 95) begin
			repeat ($urandom_range(4, 1)) tx_bytes.push_back(8'($urandom));
		end else begin
			add_env(pick_status(), pick_ana(), ENV_BODY);
			repeat ($urandom_range(5, 1)) void'(tx_bytes.pop_back());
		end
		transmit();
	endtask

	task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({index, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] low, input logic [15:0] high,
		input logic link);
		apb_write(REG_GAS_LOW, 32'(low));
		apb_write(REG_GAS_HIGH, 32'(high));
		apb_write(REG_LINK_OPEN, 32'(link));
		cfg_low = low;
		cfg_high = high;
	endtask

	initial begin
		int byte_goal;
		int result_goal;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(TAIL_BYTE);
		add_env(8'h80, 16'h0000, ENV_BODY);
		add_env(8'h00, 16'hFFFF, ENV_BODY);
		add_env(8'h01, 16'd1000, ENV_BODY);
		transmit();
		settle();
		apb_write(REG_LINK_OPEN, 32'd1);
		add_env(8'h00, GAS_LOW_RESET - 16'd1, ENV_BODY);
		add_env(8'hFF, GAS_LOW_RESET, ENV_BODY);
		add_env(8'h7F, GAS_HIGH_RESET, ENV_BODY);
		add_env(8'h00, GAS_HIGH_RESET - 16'd1, ENV_BODY);
		add_env(8'h00, 16'd700, ENV_BODY_MIN);
		add_light(16'hFFFF, LIGHT_BODY);
		add_light(16'h0000, LIGHT_BODY);
		add_light(16'h1234, 8'd3);
		add_env(8'h00, 16'd100, 8'd3);
		add_frame(8'h00, 8'd1, TAIL_BYTE);
		add_frame(8'hFF, 8'd0, TAIL_BYTE);
		transmit();
		add_wrapped_frames(2);
		transmit();

		for (int phase = 0; phase < 5; phase++) begin
			settle();
			case (phase)
				0: configure(16'h0000, 16'h0000, 1'b1);
				1: configure(16'hFFFF, 16'hFFFF, 1'b0);
				2: configure(16'd2000, 16'd300, 1'b1);
				3: configure(16'($urandom), 16'($urandom), 1'b1);
				default: configure(GAS_LOW_RESET, GAS_HIGH_RESET, 1'b1);
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 50;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 50;
				end
				default: begin
					send_idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			if (phase == 4) begin
				hold_requests++;
			end
			byte_goal = bytes_sent + 50;
			result_goal = predicted_count + 4;
			while (bytes_sent < byte_goal || predicted_count < result_goal) begin
				random_frame();
			end
		end
		settle();

		if (fail_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sensor_frame_deframer_decoder.f =====
rtl/sfdd_pkg.sv
rtl/sfdd_buffer.sv
rtl/sfdd_decode.sv
rtl/sensor_frame_deframer_decoder.sv
tb/sfdd_frame_checker.sv
tb/tb_sensor_frame_deframer_decoder.sv
